>>> rtl/core/aide_pkg.sv
// ----------------------------------------------------------------------------
// aide_pkg: shared types and constants of the array insert/delete engine
// Request and response transaction layouts, request and status codes, and
// the control word that the sequencer hands to the element memory.
// ----------------------------------------------------------------------------
package aide_pkg;

   // Array geometry
   localparam int CAPACITY = 32;
   localparam int IDX_W    = 5;   // element index width
   localparam int LEN_W    = 6;   // length width, holds CAPACITY itself
   localparam int POS_W    = 6;   // insert position width
   localparam int WORD_W   = 32;  // element width

   // Request codes
   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_INSERT = 2'd1;
   localparam logic [1:0] REQ_DELETE = 2'd2;
   localparam logic [1:0] REQ_LIST   = 2'd3;

   // Status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_PAST_END = 2'd2;

   // Request transaction
   typedef struct packed {
      logic [1:0]              req_type;
      logic [POS_W-1:0]        position;
      logic signed [WORD_W-1:0] value;
   } req_item_type;

   // Response transaction
   typedef struct packed {
      logic                     has_element;
      logic [IDX_W-1:0]         element_index;
      logic signed [WORD_W-1:0] element_value;
      logic [LEN_W-1:0]         length;
      logic [1:0]               status;
      logic                     last;
   } rsp_item_type;

   // Element memory access for one cycle
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_cmd_type;

endpackage

>>> rtl/core/aide_mem.sv
// ----------------------------------------------------------------------------
// aide_mem: element store
// One write port and one read port; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module aide_mem (
   input  logic                          clock,
   input  aide_pkg::mem_cmd_type         mem_cmd,
   output logic [aide_pkg::WORD_W-1:0]   rd_data
);

   logic [aide_pkg::WORD_W-1:0] mem_ff [aide_pkg::CAPACITY];
   logic [aide_pkg::WORD_W-1:0] rd_data_ff;

   // Write the addressed word
   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem_ff[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem_ff[mem_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/array_insert_delete_engine_core.sv
// ----------------------------------------------------------------------------
// array_insert_delete_engine_core: packed array with insert, delete, list
// Keeps up to 32 signed words and their count; appends, inserts at a
// position, deletes all words equal to a value, and lists the array.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_stall stays high until the last
// response of the request has been loaded into the output register. Cost is
// set by the element memory, whose read data is registered. An append
// writes its word in the cycle of acceptance. An insert shifts each word
// from the position up by one slot, then places the new word, and a delete
// reads each stored word once. Every request but append then lists the
// array with one read and one response load per word, or one response for
// an empty array, and rsp_stall can hold the output. The response register
// frees the next request while the final response waits.
module array_insert_delete_engine_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  aide_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output aide_pkg::rsp_item_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_DEL_SCAN,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

   state_type                       state_ff, state_in;
   logic [aide_pkg::LEN_W-1:0]      count_ff, count_in;
   logic [1:0]                      status_ff, status_in;
   logic [aide_pkg::WORD_W-1:0]     val_ff, val_in;
   logic [aide_pkg::IDX_W-1:0]      pos_ff, pos_in;
   logic [aide_pkg::IDX_W-1:0]      idx_ff, idx_in;
   logic [aide_pkg::LEN_W-1:0]      wcnt_ff, wcnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   aide_pkg::rsp_item_type          rsp_ff, rsp_in;

   aide_pkg::mem_cmd_type           mem_cmd;
   logic [aide_pkg::WORD_W-1:0]     rd_data;
   logic                            req_take;
   logic                            out_free;
   logic                            word_keep;
   logic                            emit_last;
   logic [aide_pkg::LEN_W-1:0]      idx_next;

   aide_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_next  = {1'b0, idx_ff} + aide_pkg::LEN_W'(1);
   // Compare unit: match against the request value
   assign word_keep = (rd_data != val_ff);
   assign emit_last = (count_ff == '0) || (idx_next == count_ff);

   // Sequence requests over the element memory
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      val_in       = val_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      wcnt_in      = wcnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               val_in    = req_data.value;
               pos_in    = req_data.position[aide_pkg::IDX_W-1:0];
               status_in = aide_pkg::STS_OK;
               idx_in    = '0;
               case (req_data.req_type)
                  aide_pkg::REQ_APPEND: begin
                     // Place at the end unless full; no response
                     if (count_ff < aide_pkg::LEN_W'(aide_pkg::CAPACITY)) begin
                        mem_cmd.wr_en   = 1'b1;
                        mem_cmd.wr_addr = count_ff[aide_pkg::IDX_W-1:0];
                        mem_cmd.wr_data = req_data.value;
                        count_in        = count_ff + aide_pkg::LEN_W'(1);
                     end
                  end
                  aide_pkg::REQ_INSERT: begin
                     if (count_ff >= aide_pkg::LEN_W'(aide_pkg::CAPACITY)) begin
                        status_in = aide_pkg::STS_FULL;
                        state_in  = ST_EMIT_RD;
                     end else if (req_data.position > count_ff) begin
                        status_in = aide_pkg::STS_PAST_END;
                        state_in  = ST_EMIT_RD;
                     end else if (req_data.position == count_ff) begin
                        state_in = ST_INS_PUT;
                     end else begin
                        // Start the shift at the top word
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = count_ff[aide_pkg::IDX_W-1:0]
                                          - aide_pkg::IDX_W'(1);
                        idx_in          = count_ff[aide_pkg::IDX_W-1:0];
                        state_in        = ST_INS_SHIFT;
                     end
                  end
                  aide_pkg::REQ_DELETE: begin
                     if (count_ff == '0) begin
                        state_in = ST_EMIT_RD;
                     end else begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = '0;
                        wcnt_in         = '0;
                        state_in        = ST_DEL_SCAN;
                     end
                  end
                  aide_pkg::REQ_LIST: begin
                     state_in = ST_EMIT_RD;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_INS_SHIFT: begin
            // Move the word below idx up into idx
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = idx_ff;
            mem_cmd.wr_data = rd_data;
            if ({1'b0, idx_ff} > ({1'b0, pos_ff} + aide_pkg::LEN_W'(1))) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = idx_ff - aide_pkg::IDX_W'(2);
               idx_in          = idx_ff - aide_pkg::IDX_W'(1);
            end else begin
               state_in = ST_INS_PUT;
            end
         end

         ST_INS_PUT: begin
            // Drop the new word into the opened slot
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = pos_ff;
            mem_cmd.wr_data = val_ff;
            count_in        = count_ff + aide_pkg::LEN_W'(1);
            idx_in          = '0;
            state_in        = ST_EMIT_RD;
         end

         ST_DEL_SCAN: begin
            // Compact kept words down to the write pointer
            if (word_keep) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = wcnt_ff[aide_pkg::IDX_W-1:0];
               mem_cmd.wr_data = rd_data;
            end
            if (idx_next < count_ff) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = idx_next[aide_pkg::IDX_W-1:0];
               idx_in          = idx_next[aide_pkg::IDX_W-1:0];
               wcnt_in         = wcnt_ff + aide_pkg::LEN_W'(word_keep);
            end else begin
               count_in = wcnt_ff + aide_pkg::LEN_W'(word_keep);
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end
         end

         ST_EMIT_RD: begin
            // Fetch the next word to list
            if (count_ff != '0) begin
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = idx_ff;
            end
            state_in = ST_EMIT_WR;
         end

         ST_EMIT_WR: begin
            // Load the response register once it is free
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.has_element    = (count_ff != '0);
               rsp_in.element_index  = idx_ff;
               rsp_in.element_value  = (count_ff != '0) ? rd_data : '0;
               rsp_in.length         = count_ff;
               rsp_in.status         = status_ff;
               rsp_in.last           = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_next[aide_pkg::IDX_W-1:0];
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      val_ff    <= val_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      wcnt_ff   <= wcnt_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
